// ===== src/bfi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg: shared types and constants of the Brainfuck step interpreter
// Command codes, opcode characters, error codes, register map, widths and states.
// ----------------------------------------------------------------------------
package bfi_pkg;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int PADDR_W = 12;
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 2;
    localparam int PC_W    = 13;
    localparam int CNT_W   = 25;
    localparam int MAXS_W  = 24;
    localparam int TLIM_W  = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int RIDX_W  = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TAPE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STEPS = 2'd2;

    // register indexes
    localparam logic [RIDX_W-1:0] REG_PROG_LEN  = 2'd0;
    localparam logic [RIDX_W-1:0] REG_TAPE_LIM  = 2'd1;
    localparam logic [RIDX_W-1:0] REG_MAX_STEPS = 2'd2;

    // register reset values
    localparam logic [PC_W-1:0]   RST_PROG_LEN  = 13'd0;
    localparam logic [TLIM_W-1:0] RST_TAPE_LIM  = 8'd100;
    localparam logic [MAXS_W-1:0] RST_MAX_STEPS = 24'd4000000;

    // opcode characters
    localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E; // '>'
    localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C; // '<'
    localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B; // '+'
    localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D; // '-'
    localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E; // '.'
    localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C; // ','
    localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B; // '['
    localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D; // ']'

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_SCAN_F = 6'b001000,
        ST_SCAN_B = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

endpackage

// ===== src/bfi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bf_interpreter_step.sv =====
// A load or an unused command goes from acceptance straight to the response state,
// as does a step that ends early (halted, at program end, over the step limit); an
// executed instruction passes the execute state first, and a bracket scan then walks
// program memory byte by byte through its read port. One word in flight at a time;
// reset and restart run a clearing pass that zeroes the whole tape first.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_interpreter_step: Brainfuck interpreter, one instruction per step word
// Holds program memory and byte tape in RAM; a small sequencer fetches the
// opcode and cell, executes, and walks program memory for bracket matching.
// ----------------------------------------------------------------------------
module bf_interpreter_step #(
    parameter int PROG_DEPTH = 4096,
    parameter int TAPE_CELLS = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfi_pkg::APB_AW-1:0]     paddr,
    input  logic [bfi_pkg::APB_DW-1:0]     pwdata,
    output logic [bfi_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bfi_pkg::CMD_W-1:0]      s_cmd,
    input  logic [bfi_pkg::PADDR_W-1:0]    s_prog_addr,
    input  logic [bfi_pkg::BYTE_W-1:0]     s_prog_byte,
    input  logic [bfi_pkg::BYTE_W-1:0]     s_input_byte,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_out_valid,
    output logic [bfi_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_consumed_input,
    output logic                           m_halted,
    output logic [bfi_pkg::ERR_W-1:0]      m_error_code
);

    import bfi_pkg::*;

    // program address width, tape pointer width, width of the tape limit compare
    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int TW  = $clog2(TAPE_CELLS);
    localparam int LW  = ($clog2(TAPE_CELLS + 1) > TLIM_W) ? $clog2(TAPE_CELLS + 1) : TLIM_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;

    logic [PC_W-1:0]     len_reg;
    logic [TLIM_W-1:0]   tlim_reg;
    logic [MAXS_W-1:0]   maxs_reg;

    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [TW-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                halt_reg, halt_next;
    logic [ERR_W-1:0]    err_reg, err_next;

    logic [TW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                clr_resp_reg, clr_resp_next;

    logic [PC_W-1:0]     sp_reg, sp_next;        // scan address whose byte is on rdata
    logic [PC_W-1:0]     depth_reg, depth_next;  // bracket nesting during a scan
    logic [BYTE_W-1:0]   ibyte_reg, ibyte_next;

    logic                res_ov_reg, res_ov_next;
    logic [BYTE_W-1:0]   res_ob_reg, res_ob_next;
    logic                res_ci_reg, res_ci_next;

    logic                m_valid_reg;
    logic                m_out_valid_reg;
    logic [BYTE_W-1:0]   m_out_byte_reg;
    logic                m_consumed_reg;
    logic                m_halted_reg;
    logic [ERR_W-1:0]    m_err_reg;

    // ------------------------------------------------------------------
    // Memory side signals
    // ------------------------------------------------------------------
    logic [PC_W-1:0]       prd_pc;               // program address to read this cycle
    logic [PC_W+PAW-1:0]   prd_wide;
    logic [PAW-1:0]        prd_addr;
    logic                  prd_rng_reg;          // read address was inside program memory
    logic [BYTE_W-1:0]     prog_rdata;
    logic [BYTE_W-1:0]     op;

    logic                  p_we;
    logic [PADDR_W+PAW-1:0] ld_wide;
    logic [PAW-1:0]        ld_addr;
    logic                  ld_rng;

    logic                  t_we;
    logic [TW-1:0]         t_waddr;
    logic [BYTE_W-1:0]     t_wdata;
    logic [BYTE_W-1:0]     t_rdata;

    // ------------------------------------------------------------------
    // Step helpers
    // ------------------------------------------------------------------
    logic [LW-1:0]         lim_tl, lim_cells, limit, ptr_inc;
    logic                  fin;                  // instruction retired this cycle
    logic [PC_W:0]         pc_fin;               // pc after the retiring instruction
    logic                  m_load;
    logic                  cfg_wr;
    logic                  accept;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait writes and reads
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_PROG_LEN:  prdata = APB_DW'(len_reg);
            REG_TAPE_LIM:  prdata = APB_DW'(tlim_reg);
            REG_MAX_STEPS: prdata = APB_DW'(maxs_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Program memory: loads write, the sequencer reads one byte per cycle
    // ------------------------------------------------------------------
    assign ld_wide  = {{PAW{1'b0}}, s_prog_addr};
    assign ld_addr  = ld_wide[PAW-1:0];
    assign ld_rng   = 32'(s_prog_addr) < 32'(PROG_DEPTH);

    assign prd_wide = {{PAW{1'b0}}, prd_pc};
    assign prd_addr = prd_wide[PAW-1:0];

    // bytes past the end of program memory read as a no-op
    assign op = prd_rng_reg ? prog_rdata : '0;

    always_ff @(posedge aclk) begin
        prd_rng_reg <= 32'(prd_pc) < 32'(PROG_DEPTH);
    end

    bfi_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (ld_addr),
        .wdata (s_prog_byte),
        .raddr (prd_addr),
        .rdata (prog_rdata)
    );

    // Tape: always read at the pointer, so the cell is ready the cycle after accept
    bfi_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (ptr_reg),
        .rdata (t_rdata)
    );

    // effective tape limit is the smaller of the register and the tape size
    assign lim_tl    = LW'(tlim_reg);
    assign lim_cells = LW'(TAPE_CELLS);
    assign limit     = (lim_tl < lim_cells) ? lim_tl : lim_cells;
    assign ptr_inc   = LW'(ptr_reg) + LW'(1);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_load  = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        halt_next     = halt_reg;
        err_next      = err_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        sp_next       = sp_reg;
        depth_next    = depth_reg;
        ibyte_next    = ibyte_reg;
        res_ov_next   = res_ov_reg;
        res_ob_next   = res_ob_reg;
        res_ci_next   = res_ci_reg;
        prd_pc        = pc_reg;
        p_we          = 1'b0;
        t_we          = 1'b0;
        t_waddr       = ptr_reg;
        t_wdata       = '0;
        fin           = 1'b0;
        pc_fin        = {1'b0, pc_reg} + (PC_W+1)'(1);

        case (state_reg)
            ST_CLEAR: begin
                // sweep zeros through the tape, one cell per cycle
                t_we         = 1'b1;
                t_waddr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + TW'(1);
                if (clr_cnt_reg == TW'(TAPE_CELLS - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    res_ov_next = 1'b0;
                    res_ob_next = '0;
                    res_ci_next = 1'b0;
                    ibyte_next  = s_input_byte;
                    state_next  = ST_RESP;
                    case (s_cmd)
                        CMD_LOAD: begin
                            p_we = ld_rng;
                        end
                        CMD_RESTART: begin
                            pc_next       = '0;
                            ptr_next      = '0;
                            cnt_next      = '0;
                            halt_next     = 1'b0;
                            err_next      = ERR_NONE;
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_STEP: begin
                            if (halt_reg) begin
                                state_next = ST_RESP;
                            end else if (pc_reg >= len_reg) begin
                                halt_next = 1'b1;
                            end else if (cnt_reg > {1'b0, maxs_reg}) begin
                                halt_next = 1'b1;
                                err_next  = ERR_STEPS;
                            end else begin
                                state_next = ST_EXEC;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_EXEC: begin
                case (op)
                    OP_RIGHT: begin
                        if (ptr_inc >= limit) begin
                            halt_next  = 1'b1;
                            err_next   = ERR_TAPE;
                            state_next = ST_RESP;
                        end else begin
                            ptr_next = ptr_reg + TW'(1);
                            fin      = 1'b1;
                        end
                    end
                    OP_LEFT: begin
                        if (ptr_reg == '0) begin
                            halt_next  = 1'b1;
                            err_next   = ERR_TAPE;
                            state_next = ST_RESP;
                        end else begin
                            ptr_next = ptr_reg - TW'(1);
                            fin      = 1'b1;
                        end
                    end
                    OP_INC: begin
                        t_we    = 1'b1;
                        t_wdata = t_rdata + BYTE_W'(1);
                        fin     = 1'b1;
                    end
                    OP_DEC: begin
                        t_we    = 1'b1;
                        t_wdata = t_rdata - BYTE_W'(1);
                        fin     = 1'b1;
                    end
                    OP_OUT: begin
                        res_ov_next = 1'b1;
                        res_ob_next = t_rdata;
                        fin         = 1'b1;
                    end
                    OP_IN: begin
                        res_ci_next = 1'b1;
                        t_we        = 1'b1;
                        t_wdata     = ibyte_reg;
                        fin         = 1'b1;
                    end
                    OP_OPEN: begin
                        if (t_rdata == '0) begin
                            sp_next    = pc_reg + PC_W'(1);
                            prd_pc     = pc_reg + PC_W'(1);
                            depth_next = '0;
                            state_next = ST_SCAN_F;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_CLOSE: begin
                        if (t_rdata == '0) begin
                            fin = 1'b1;
                        end else if (pc_reg == '0) begin
                            // nothing to walk back over: resume at the start
                            pc_fin = '0;
                            fin    = 1'b1;
                        end else begin
                            sp_next    = pc_reg - PC_W'(1);
                            prd_pc     = pc_reg - PC_W'(1);
                            depth_next = '0;
                            state_next = ST_SCAN_B;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            ST_SCAN_F: begin
                // stop at the matching close or at the program end
                if (sp_reg >= len_reg || (op == OP_CLOSE && depth_reg == '0)) begin
                    pc_fin = {1'b0, sp_reg} + (PC_W+1)'(1);
                    fin    = 1'b1;
                end else begin
                    if (op == OP_OPEN) begin
                        depth_next = depth_reg + PC_W'(1);
                    end else if (op == OP_CLOSE) begin
                        depth_next = depth_reg - PC_W'(1);
                    end
                    sp_next = sp_reg + PC_W'(1);
                    prd_pc  = sp_reg + PC_W'(1);
                end
            end

            ST_SCAN_B: begin
                if (op == OP_OPEN && depth_reg == '0) begin
                    pc_fin = {1'b0, sp_reg} + (PC_W+1)'(1);
                    fin    = 1'b1;
                end else begin
                    if (op == OP_CLOSE) begin
                        depth_next = depth_reg + PC_W'(1);
                    end else if (op == OP_OPEN) begin
                        depth_next = depth_reg - PC_W'(1);
                    end
                    if (sp_reg == '0) begin
                        // unmatched close: walk off the start, resume at pc 0
                        pc_fin = '0;
                        fin    = 1'b1;
                    end else begin
                        sp_next = sp_reg - PC_W'(1);
                        prd_pc  = sp_reg - PC_W'(1);
                    end
                end
            end

            ST_RESP: begin
                // hold until the output register is free
                if (m_load) begin
                    clr_resp_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // retire: count the step, advance pc, halt at the program end
        if (fin) begin
            cnt_next   = cnt_reg + CNT_W'(1);
            pc_next    = pc_fin[PC_W-1:0];
            if (pc_fin >= {1'b0, len_reg}) begin
                halt_next = 1'b1;
            end
            state_next = ST_RESP;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            len_reg      <= RST_PROG_LEN;
            tlim_reg     <= RST_TAPE_LIM;
            maxs_reg     <= RST_MAX_STEPS;
            pc_reg       <= '0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            halt_reg     <= 1'b0;
            err_reg      <= ERR_NONE;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            halt_reg     <= halt_next;
            err_reg      <= err_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            if (cfg_wr) begin
                case (paddr[APB_AW-1:2])
                    REG_PROG_LEN:  len_reg  <= pwdata[PC_W-1:0];
                    REG_TAPE_LIM:  tlim_reg <= pwdata[TLIM_W-1:0];
                    REG_MAX_STEPS: maxs_reg <= pwdata[MAXS_W-1:0];
                    default: ;
                endcase
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sp_reg     <= sp_next;
        depth_reg  <= depth_next;
        ibyte_reg  <= ibyte_next;
        res_ov_reg <= res_ov_next;
        res_ob_reg <= res_ob_next;
        res_ci_reg <= res_ci_next;
        if (m_load) begin
            m_out_valid_reg <= res_ov_reg;
            m_out_byte_reg  <= res_ob_reg;
            m_consumed_reg  <= res_ci_reg;
            m_halted_reg    <= halt_reg;
            m_err_reg       <= err_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_valid      = m_out_valid_reg;
    assign m_out_byte       = m_out_byte_reg;
    assign m_consumed_input = m_consumed_reg;
    assign m_halted         = m_halted_reg;
    assign m_error_code     = m_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE) |-> halt_reg)
        else $error("error code set without halt");

    a_halt_clears_on_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(halt_reg) && $past(aresetn)) |->
            $past(s_valid && s_ready && s_cmd == CMD_RESTART))
        else $error("halt cleared without restart");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cnt_reg != $past(cnt_reg)) && $past(aresetn)) |->
            (cnt_reg == $past(cnt_reg) + CNT_W'(1) || cnt_reg == '0))
        else $error("step count moved by more than one");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result word raised outside response state");

endmodule
